/* hdl/tskf_pkg.sv */
`timescale 1ns / 1ps
package tskf_pkg;
  localparam int FracBitsDef = 16;
  localparam int WordBitsDef = 32;
  localparam int NumRegs     = 7;
  localparam int AddrBits    = 6;

  // register indexes
  localparam logic [2:0] RegA01 = 3'd0;
  localparam logic [2:0] RegA23 = 3'd1;
  localparam logic [2:0] RegB   = 3'd2;
  localparam logic [2:0] RegC   = 3'd3;
  localparam logic [2:0] RegQ01 = 3'd4;
  localparam logic [2:0] RegQ23 = 3'd5;
  localparam logic [2:0] RegR   = 3'd6;

  // ALU operations
  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpNeg = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic                  start;
    alu_op_e               op;
  } alu_ctrl_t;
endpackage

/* hdl/tskf_stream_if.sv */
`timescale 1ns / 1ps
interface tskf_stream_if #(
  parameter int W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/two_state_kalman_filter.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_s      in   {measurement, rate_input}
// out_m     out  {singular, overflow, estimate_second, estimate_first}
// apb       in   7 x 64-bit registers at 8*i
// One transaction runs from accept through a load state, microcode over one
// shared saturating ALU, two divides, a write-back state and a result state
// that holds until the result is taken.
// Zero innovation variance ends the sequence early, before the divides.
// Ready is low while a transaction is in work and while a result waits.
// Reset clears state to zero and registers to their defaults.
module two_state_kalman_filter
  import tskf_pkg::*;
#(
  parameter int FracBits = FracBitsDef,
  parameter int WordBits = WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tskf_stream_if.sink         in_s,
  tskf_stream_if.source       out_m,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  localparam logic signed [WordBits-1:0] One = WordBits'(64'sd1 <<< FracBits);
  localparam logic signed [31:0] WMax32 = 32'((64'sd1 <<< (WordBits - 1)) - 1);
  localparam logic signed [31:0] WMin32 = -WMax32 - 32'sd1;

  // scratch register file indexes
  typedef enum logic [5:0] {
    RA0, RA1, RA2, RA3, RB0, RB1, RC0, RC1, RQ0, RQ1, RQ2, RQ3, RR, RU, RZ, ROne,
    X0, X1, P11, P12, P21, P22,
    XP0, XP1, T0, T1, T2, R00, R01, R10, R11, N11, N12, N21, N22, S,
    L1, L2, E, K11, K12, K21, K22, NX0, NX1, NUM
  } slot_e;

  // slots from X0 up live in the scratch file, the rest are read in place
  function automatic logic [4:0] ri(input slot_e sl);
    ri = 5'(sl - X0);
  endfunction

  typedef struct packed {
    alu_op_e op;
    slot_e   a;
    slot_e   b;
    slot_e   d;
  } uop_t;

  localparam int NUops = 62;
  localparam int PcW   = $clog2(NUops + 1);

  function automatic uop_t uop(input logic [PcW-1:0] pc);
    unique case (pc)
      0:  uop = '{OpMul, RA0, X0, T0};
      1:  uop = '{OpMul, RA1, X1, T1};
      2:  uop = '{OpAdd, T0, T1, T0};
      3:  uop = '{OpMul, RB0, RU, T1};
      4:  uop = '{OpAdd, T0, T1, XP0};
      5:  uop = '{OpMul, RA2, X0, T0};
      6:  uop = '{OpMul, RA3, X1, T1};
      7:  uop = '{OpAdd, T0, T1, T0};
      8:  uop = '{OpMul, RB1, RU, T1};
      9:  uop = '{OpAdd, T0, T1, XP1};
      10: uop = '{OpMul, RA0, P11, T0};
      11: uop = '{OpMul, RA1, P21, T1};
      12: uop = '{OpAdd, T0, T1, R00};
      13: uop = '{OpMul, RA0, P12, T0};
      14: uop = '{OpMul, RA1, P22, T1};
      15: uop = '{OpAdd, T0, T1, R01};
      16: uop = '{OpMul, RA2, P11, T0};
      17: uop = '{OpMul, RA3, P21, T1};
      18: uop = '{OpAdd, T0, T1, R10};
      19: uop = '{OpMul, RA2, P12, T0};
      20: uop = '{OpMul, RA3, P22, T1};
      21: uop = '{OpAdd, T0, T1, R11};
      22: uop = '{OpMul, RA0, R00, T0};
      23: uop = '{OpMul, RA1, R01, T1};
      24: uop = '{OpAdd, T0, T1, T0};
      25: uop = '{OpAdd, T0, RQ0, N11};
      26: uop = '{OpMul, RA2, R00, T0};
      27: uop = '{OpMul, RA3, R01, T1};
      28: uop = '{OpAdd, T0, T1, T0};
      29: uop = '{OpAdd, T0, RQ1, N12};
      30: uop = '{OpMul, RA0, R10, T0};
      31: uop = '{OpMul, RA1, R11, T1};
      32: uop = '{OpAdd, T0, T1, T0};
      33: uop = '{OpAdd, T0, RQ2, N21};
      34: uop = '{OpMul, RA2, R10, T0};
      35: uop = '{OpMul, RA3, R11, T1};
      36: uop = '{OpAdd, T0, T1, T0};
      37: uop = '{OpAdd, T0, RQ3, N22};
      // S = c0*(c0 p11 + c1 p21) + c1*(c0 p12 + c1 p22) + r
      38: uop = '{OpMul, RC0, N11, T0};
      39: uop = '{OpMul, RC1, N21, T1};
      40: uop = '{OpAdd, T0, T1, T0};
      41: uop = '{OpMul, RC0, T0, T2};
      42: uop = '{OpMul, RC0, N12, T0};
      43: uop = '{OpMul, RC1, N22, T1};
      44: uop = '{OpAdd, T0, T1, T0};
      45: uop = '{OpMul, RC1, T0, T0};
      46: uop = '{OpAdd, T2, T0, T0};
      47: uop = '{OpAdd, T0, RR, S};
      // numerators for L1 and L2 (each then divided)
      48: uop = '{OpMul, N11, RC0, T0};
      49: uop = '{OpMul, N12, RC1, T1};
      50: uop = '{OpAdd, T0, T1, NUM};
      51: uop = '{OpMul, N21, RC0, T0};
      52: uop = '{OpMul, N22, RC1, T1};
      53: uop = '{OpAdd, T0, T1, NUM};
      // innovation and gain terms
      54: uop = '{OpMul, RC0, XP0, T0};
      55: uop = '{OpSub, RZ, T0, T0};
      56: uop = '{OpMul, RC1, XP1, T1};
      57: uop = '{OpSub, T0, T1, E};
      58: uop = '{OpMul, L1, RC0, T0};
      59: uop = '{OpSub, ROne, T0, K11};
      60: uop = '{OpMul, L1, RC1, K12};
      default: uop = '{OpNeg, L2, L2, T0};
    endcase
  endfunction

  // second microcode bank, after the first
  function automatic uop_t uop2(input logic [PcW-1:0] pc);
    unique case (pc)
      0:  uop2 = '{OpMul, T0, RC0, K21};
      1:  uop2 = '{OpMul, L2, RC1, T0};
      2:  uop2 = '{OpSub, ROne, T0, K22};
      3:  uop2 = '{OpMul, L1, E, T0};
      4:  uop2 = '{OpAdd, XP0, T0, NX0};
      5:  uop2 = '{OpMul, L2, E, T0};
      6:  uop2 = '{OpAdd, XP1, T0, NX1};
      7:  uop2 = '{OpMul, K11, N11, T0};
      8:  uop2 = '{OpMul, K12, N21, T1};
      9:  uop2 = '{OpSub, T0, T1, R00};
      10: uop2 = '{OpMul, K11, N12, T0};
      11: uop2 = '{OpMul, K12, N22, T1};
      12: uop2 = '{OpSub, T0, T1, R01};
      13: uop2 = '{OpMul, K21, N11, T0};
      14: uop2 = '{OpMul, K22, N21, T1};
      15: uop2 = '{OpAdd, T0, T1, R10};
      16: uop2 = '{OpMul, K21, N12, T0};
      17: uop2 = '{OpMul, K22, N22, T1};
      default: uop2 = '{OpAdd, T0, T1, R11};
    endcase
  endfunction

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StLoad  = 7'b0000010,
    StExec  = 7'b0000100,
    StDiv   = 7'b0001000,
    StExec2 = 7'b0010000,
    StWrite = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [PcW-1:0] pc_q;
  logic phase_q;       // set once a multiply's product is registered
  logic div_sel_q;     // 0: L1, 1: L2
  logic bank_q;
  logic ovf_q, sing_q;
  logic signed [WordBits-1:0] rf_q [30];
  logic signed [WordBits-1:0] u_q, z_q;

  logic [63:0] reg_q [NumRegs];
  logic [2:0]  widx;

  // configuration port
  assign pready = 1'b1;
  assign widx   = paddr[5:3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q[RegA01] <= 64'd65536;
      reg_q[RegA23] <= 64'd65536 << 32;
      reg_q[RegB]   <= '0;
      reg_q[RegC]   <= 64'd65536;
      reg_q[RegQ01] <= '0;
      reg_q[RegQ23] <= '0;
      reg_q[RegR]   <= 64'd65536;
    end else if (psel && penable && pwrite && widx < 3'(NumRegs)) begin
      if (widx == RegR) reg_q[widx] <= {32'd0, pwdata[31:0]};
      else              reg_q[widx] <= pwdata;
    end
  end
  always_comb begin
    prdata = '0;
    if (widx < 3'(NumRegs)) prdata = reg_q[widx];
  end

  // word saturation of a 32-bit operand
  function automatic logic [WordBits:0] satw(input logic signed [31:0] v);
    if (v > WMax32)      satw = {1'b1, WordBits'(WMax32)};
    else if (v < WMin32) satw = {1'b1, WordBits'(WMin32)};
    else                 satw = {1'b0, WordBits'(v)};
  endfunction

  uop_t cur;
  alu_ctrl_t ctl;
  logic signed [WordBits-1:0] alu_res, quo, op_a, op_b;
  logic alu_sat, div_done, div_sat, div_start;

  assign cur = bank_q ? uop2(pc_q) : uop(pc_q);
  assign ctl = '{start: 1'b1, op: cur.op};

  tskf_alu #(.FracBits(FracBits), .WordBits(WordBits)) u_alu (
    .clk_i, .ctrl_i(ctl), .a_i(op_a), .b_i(op_b),
    .res_o(alu_res), .sat_o(alu_sat)
  );

  // the numerator is taken straight off the ALU in the step that forms it
  tskf_div #(.FracBits(FracBits), .WordBits(WordBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(alu_res), .den_i(rf_q[ri(S)]),
    .done_o(div_done), .quo_o(quo), .sat_o(div_sat)
  );

  logic step_done;
  assign step_done = (state_q == StExec || state_q == StExec2) &&
                     (cur.op != OpMul || phase_q);
  // divide after numerator of L1 (pc 50) and L2 (pc 53)
  assign div_start = step_done && !bank_q && (pc_q == PcW'(50) || pc_q == PcW'(53))
                     && rf_q[ri(S)] != '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_s.valid) state_d = StLoad;
      StLoad:  state_d = StExec;
      StExec: begin
        if (step_done) begin
          if (pc_q == PcW'(47) && alu_res == '0) state_d = StWrite;
          else if (div_start) state_d = StDiv;
          else if (pc_q == PcW'(NUops - 1)) state_d = StExec2;
        end
      end
      StDiv:   if (div_done) state_d = StExec;
      StExec2: if (step_done && pc_q == PcW'(18)) state_d = StWrite;
      StWrite: state_d = StOut;
      StOut:   if (out_m.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign in_s.ready  = state_q == StIdle;
  assign out_m.valid = state_q == StOut;
  assign out_m.data  = {sing_q, ovf_q, 32'(rf_q[ri(X1)]), 32'(rf_q[ri(X0)])};

  logic [WordBits:0] s_a0, s_a1, s_a2, s_a3, s_b0, s_b1, s_c0, s_c1,
                     s_q0, s_q1, s_q2, s_q3, s_r, s_u, s_z;
  assign s_a0 = satw(reg_q[RegA01][31:0]);
  assign s_a1 = satw(reg_q[RegA01][63:32]);
  assign s_a2 = satw(reg_q[RegA23][31:0]);
  assign s_a3 = satw(reg_q[RegA23][63:32]);
  assign s_b0 = satw(reg_q[RegB][31:0]);
  assign s_b1 = satw(reg_q[RegB][63:32]);
  assign s_c0 = satw(reg_q[RegC][31:0]);
  assign s_c1 = satw(reg_q[RegC][63:32]);
  assign s_q0 = satw(reg_q[RegQ01][31:0]);
  assign s_q1 = satw(reg_q[RegQ01][63:32]);
  assign s_q2 = satw(reg_q[RegQ23][31:0]);
  assign s_q3 = satw(reg_q[RegQ23][63:32]);
  assign s_r  = satw(reg_q[RegR][31:0]);
  assign s_u  = satw(in_s.data[31:0]);
  assign s_z  = satw(in_s.data[63:32]);

  // coefficients are read from the registers, which must hold still while a
  // transaction is in work; the block itself does not enforce this
  function automatic logic signed [WordBits-1:0] rd(input slot_e sl);
    unique case (sl)
      RA0:     rd = s_a0[WordBits-1:0];
      RA1:     rd = s_a1[WordBits-1:0];
      RA2:     rd = s_a2[WordBits-1:0];
      RA3:     rd = s_a3[WordBits-1:0];
      RB0:     rd = s_b0[WordBits-1:0];
      RB1:     rd = s_b1[WordBits-1:0];
      RC0:     rd = s_c0[WordBits-1:0];
      RC1:     rd = s_c1[WordBits-1:0];
      RQ0:     rd = s_q0[WordBits-1:0];
      RQ1:     rd = s_q1[WordBits-1:0];
      RQ2:     rd = s_q2[WordBits-1:0];
      RQ3:     rd = s_q3[WordBits-1:0];
      RR:      rd = s_r[WordBits-1:0];
      RU:      rd = u_q;
      RZ:      rd = z_q;
      ROne:    rd = One;
      default: rd = rf_q[ri(sl)];
    endcase
  endfunction

  always_comb begin
    op_a = rd(cur.a);
    op_b = rd(cur.b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pc_q      <= '0;
      phase_q   <= 1'b0;
      bank_q    <= 1'b0;
      div_sel_q <= 1'b0;
      ovf_q     <= 1'b0;
      sing_q    <= 1'b0;
      rf_q[ri(X0)]  <= '0;
      rf_q[ri(X1)]  <= '0;
      rf_q[ri(P11)] <= '0;
      rf_q[ri(P12)] <= '0;
      rf_q[ri(P21)] <= '0;
      rf_q[ri(P22)] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: if (in_s.valid) begin
          u_q <= s_u[WordBits-1:0];
          z_q <= s_z[WordBits-1:0];
          ovf_q  <= s_a0[WordBits] | s_a1[WordBits] | s_a2[WordBits] | s_a3[WordBits] |
                    s_b0[WordBits] | s_b1[WordBits] | s_c0[WordBits] | s_c1[WordBits] |
                    s_q0[WordBits] | s_q1[WordBits] | s_q2[WordBits] | s_q3[WordBits] |
                    s_r[WordBits] | s_u[WordBits] | s_z[WordBits];
          sing_q <= 1'b0;
          pc_q   <= '0;
          bank_q <= 1'b0;
          phase_q <= 1'b0;
          div_sel_q <= 1'b0;
        end
        StLoad: ;
        StExec, StExec2: begin
          if (cur.op == OpMul && !phase_q) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            rf_q[ri(cur.d)] <= alu_res;
            ovf_q <= ovf_q | alu_sat;
            if (state_q == StExec && pc_q == PcW'(NUops - 1)) begin
              bank_q <= 1'b1;
              pc_q   <= '0;
            end else begin
              pc_q <= pc_q + 1'b1;
            end
            if (state_q == StExec && pc_q == PcW'(47) && alu_res == '0) begin
              sing_q <= 1'b1;
            end
          end
        end
        StDiv: if (div_done) begin
          rf_q[div_sel_q ? ri(L2) : ri(L1)] <= quo;
          ovf_q <= ovf_q | div_sat;
          div_sel_q <= 1'b1;
        end
        StWrite: begin
          if (sing_q) begin
            rf_q[ri(X0)] <= rf_q[ri(XP0)]; rf_q[ri(X1)] <= rf_q[ri(XP1)];
            rf_q[ri(P11)] <= rf_q[ri(N11)]; rf_q[ri(P12)] <= rf_q[ri(N12)];
            rf_q[ri(P21)] <= rf_q[ri(N21)]; rf_q[ri(P22)] <= rf_q[ri(N22)];
          end else begin
            rf_q[ri(X0)] <= rf_q[ri(NX0)]; rf_q[ri(X1)] <= rf_q[ri(NX1)];
            rf_q[ri(P11)] <= rf_q[ri(R00)]; rf_q[ri(P12)] <= rf_q[ri(R01)];
            rf_q[ri(P21)] <= rf_q[ri(R10)]; rf_q[ri(P22)] <= rf_q[ri(R11)];
          end
        end
        StOut: ;
        default: ;
      endcase
    end
  end

  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_s.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && !out_m.ready |=> out_m.valid && $stable(out_m.data))
    else $error("result dropped");
  a_div_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> state_q == StExec && !sing_q) else $error("bad divide start");
endmodule

/* hdl/tskf_alu.sv */
`timescale 1ns / 1ps
// Shared saturating unit: add, subtract, negate and rounded fixed-point
// multiply. Multiply is registered once before rounding.
module tskf_alu
  import tskf_pkg::*;
#(
  parameter int FracBits = FracBitsDef,
  parameter int WordBits = WordBitsDef
) (
  input  logic                       clk_i,
  input  alu_ctrl_t                  ctrl_i,
  input  logic signed [WordBits-1:0] a_i,
  input  logic signed [WordBits-1:0] b_i,
  output logic signed [WordBits-1:0] res_o,
  output logic                       sat_o
);
  localparam int PW = 2 * WordBits;
  localparam logic signed [PW:0] WMax = (PW+1)'((64'sd1 <<< (WordBits - 1)) - 1);
  localparam logic signed [PW:0] WMin = -WMax - (PW+1)'(1);

  logic signed [PW-1:0] prod_q;
  logic signed [PW:0]   wide;
  logic signed [PW:0]   rnd;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(a_i) * PW'(b_i);
  end

  always_comb begin
    rnd = (PW+1)'(prod_q) + ((PW+1)'(1) <<< (FracBits - 1));
    unique case (ctrl_i.op)
      OpAdd:   wide = (PW+1)'(a_i) + (PW+1)'(b_i);
      OpSub:   wide = (PW+1)'(a_i) - (PW+1)'(b_i);
      OpNeg:   wide = -(PW+1)'(a_i);
      default: wide = rnd >>> FracBits;
    endcase
    sat_o = 1'b0;
    if (wide > WMax) begin
      res_o = WordBits'(WMax);
      sat_o = 1'b1;
    end else if (wide < WMin) begin
      res_o = WordBits'(WMin);
      sat_o = 1'b1;
    end else begin
      res_o = WordBits'(wide);
    end
  end
endmodule

/* hdl/tskf_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: (num << FracBits) / den,
// truncated toward zero, saturated to the word.
module tskf_div
  import tskf_pkg::*;
#(
  parameter int FracBits = FracBitsDef,
  parameter int WordBits = WordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [WordBits-1:0] num_i,
  input  logic signed [WordBits-1:0] den_i,
  output logic                       done_o,
  output logic signed [WordBits-1:0] quo_o,
  output logic                       sat_o
);
  localparam int NW = WordBits + FracBits;
  localparam int CW = $clog2(NW + 1);
  localparam logic [NW:0] QMax = (NW+1)'((64'd1 << (WordBits - 1)) - 1);

  logic [NW-1:0]   dvd_q;
  logic [WordBits:0] rem_q;
  logic [WordBits-1:0] den_q;
  logic            neg_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic [WordBits:0] trial;
  logic [NW:0]     mag;

  always_comb begin
    trial = {rem_q[WordBits-1:0], dvd_q[NW-1]} - {1'b0, den_q};
    mag   = {1'b0, dvd_q};
    sat_o = 1'b0;
    if (!neg_q && mag > QMax) begin
      quo_o = WordBits'(QMax);
      sat_o = 1'b1;
    end else if (neg_q && mag > QMax + 1'b1) begin
      quo_o = WordBits'(-(QMax + 1'b1));
      sat_o = 1'b1;
    end else if (neg_q) begin
      quo_o = WordBits'(-mag);
    end else begin
      quo_o = WordBits'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // magnitude taken at word width, so the most negative word maps to 2^(W-1)
      dvd_q <= NW'({{FracBits{1'b0}}, num_i[WordBits-1] ? -num_i : num_i}) << FracBits;
      den_q <= den_i[WordBits-1] ? -den_i : den_i;
      rem_q <= '0;
      neg_q <= num_i[WordBits-1] ^ den_i[WordBits-1];
    end else if (busy_q) begin
      if (!trial[WordBits]) begin
        rem_q <= trial;
        dvd_q <= {dvd_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[WordBits-1:0], dvd_q[NW-1]};
        dvd_q <= {dvd_q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import tskf_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int FRAC = FracBitsDef;
  localparam int DRAIN_CYCLES = 400;
  localparam longint LIMIT_NS = 64'd16_000_000;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
    logic        ovf;
    logic        sing;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  tskf_stream_if #(.W(64)) in_if ();
  tskf_stream_if #(.W(66)) out_if ();

  two_state_kalman_filter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_if),
    .out_m  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("two_state_kalman_filter regression: fail");
    $finish;
  end

  // filter model: registers, state, covariance
  logic [63:0] m_a01, m_a23, m_b, m_c, m_q01, m_q23, m_r;
  longint est_x0, est_x1, cv11, cv12, cv21, cv22;
  bit sat_hit;

  estimate_t estimate_q[$];
  int n_errors = 0;
  bit idle_en = 1'b1;
  int hold_cycles = 0;
  bit long_hold = 1'b0;

  function automatic longint clip(longint v);
    if (v > WMAX) begin
      sat_hit = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat_hit = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic longint sx(logic [31:0] w);
    return longint'($signed(w));
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clip(a - b);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC - 1));
    return clip(p >>> FRAC);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    return clip((num * (64'sd1 <<< FRAC)) / den);
  endfunction

  function automatic estimate_t filter_step(logic [31:0] u_w, logic [31:0] z_w);
    longint a0, a1, a2, a3, b0, b1, c0, c1, q0, q1, q2, q3, r, u, z, one;
    longint xp0, xp1, r00, r01, r10, r11, p11, p12, p21, p22, s;
    longint l1, l2, e, k11, k12, k21, k22;
    estimate_t res;
    sat_hit = 1'b0;
    a0 = sx(m_a01[31:0]); a1 = sx(m_a01[63:32]);
    a2 = sx(m_a23[31:0]); a3 = sx(m_a23[63:32]);
    b0 = sx(m_b[31:0]);   b1 = sx(m_b[63:32]);
    c0 = sx(m_c[31:0]);   c1 = sx(m_c[63:32]);
    q0 = sx(m_q01[31:0]); q1 = sx(m_q01[63:32]);
    q2 = sx(m_q23[31:0]); q3 = sx(m_q23[63:32]);
    r = sx(m_r[31:0]);
    u = sx(u_w);
    z = sx(z_w);
    one = 64'sd1 <<< FRAC;

    xp0 = fx_add(fx_add(fx_mul(a0, est_x0), fx_mul(a1, est_x1)), fx_mul(b0, u));
    xp1 = fx_add(fx_add(fx_mul(a2, est_x0), fx_mul(a3, est_x1)), fx_mul(b1, u));
    r00 = fx_add(fx_mul(a0, cv11), fx_mul(a1, cv21));
    r01 = fx_add(fx_mul(a0, cv12), fx_mul(a1, cv22));
    r10 = fx_add(fx_mul(a2, cv11), fx_mul(a3, cv21));
    r11 = fx_add(fx_mul(a2, cv12), fx_mul(a3, cv22));
    p11 = fx_add(fx_add(fx_mul(a0, r00), fx_mul(a1, r01)), q0);
    p12 = fx_add(fx_add(fx_mul(a2, r00), fx_mul(a3, r01)), q1);
    p21 = fx_add(fx_add(fx_mul(a0, r10), fx_mul(a1, r11)), q2);
    p22 = fx_add(fx_add(fx_mul(a2, r10), fx_mul(a3, r11)), q3);
    s = fx_add(fx_add(fx_mul(c0, fx_add(fx_mul(c0, p11), fx_mul(c1, p21))),
                      fx_mul(c1, fx_add(fx_mul(c0, p12), fx_mul(c1, p22)))), r);

    res.sing = (s == 0);
    if (s == 0) begin
      est_x0 = xp0; est_x1 = xp1;
      cv11 = p11; cv12 = p12; cv21 = p21; cv22 = p22;
    end else begin
      l1 = fx_div(fx_add(fx_mul(p11, c0), fx_mul(p12, c1)), s);
      l2 = fx_div(fx_add(fx_mul(p21, c0), fx_mul(p22, c1)), s);
      e = fx_sub(fx_sub(z, fx_mul(c0, xp0)), fx_mul(c1, xp1));
      k11 = fx_sub(one, fx_mul(l1, c0));
      k12 = fx_mul(l1, c1);
      k21 = fx_mul(clip(-l2), c0);
      k22 = fx_sub(one, fx_mul(l2, c1));
      est_x0 = fx_add(xp0, fx_mul(l1, e));
      est_x1 = fx_add(xp1, fx_mul(l2, e));
      cv11 = fx_sub(fx_mul(k11, p11), fx_mul(k12, p21));
      cv12 = fx_sub(fx_mul(k11, p12), fx_mul(k12, p22));
      cv21 = fx_add(fx_mul(k21, p11), fx_mul(k22, p21));
      cv22 = fx_add(fx_mul(k21, p12), fx_mul(k22, p22));
    end
    res.first = est_x0[31:0];
    res.second = est_x1[31:0];
    res.ovf = sat_hit;
    return res;
  endfunction

  // mostly modest magnitudes, sometimes anything, sometimes the rails
  function automatic logic [31:0] rand_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    if (sel < 8) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrBits'(idx) << 3;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegA01: m_a01 = value;
      RegA23: m_a23 = value;
      RegB:   m_b = value;
      RegC:   m_c = value;
      RegQ01: m_q01 = value;
      RegQ23: m_q23 = value;
      RegR:   m_r = {32'h0, value[31:0]};
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    // drop valid so the last transaction is not taken a second time
    in_if.valid <= 1'b0;
    wait (estimate_q.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(logic [63:0] a01, logic [63:0] a23, logic [63:0] b,
                             logic [63:0] c, logic [63:0] q01, logic [63:0] q23,
                             logic [31:0] r);
    wait_idle();
    write_reg(RegA01, a01);
    write_reg(RegA23, a23);
    write_reg(RegB, b);
    write_reg(RegC, c);
    write_reg(RegQ01, q01);
    write_reg(RegQ23, q23);
    write_reg(RegR, {32'h0, r});
  endtask

  task automatic send_item(logic [31:0] u, logic [31:0] z);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= {z, u};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    estimate_q.push_back(filter_step(u, z));
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  // result side: random stalls, optional long hold, compare against the model
  always @(posedge clk_i) begin
    estimate_t exp_e;
    if (out_if.valid && out_if.ready) begin
      if (estimate_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", out_if.data);
      end else begin
        exp_e = estimate_q.pop_front();
        if (out_if.data[31:0] !== exp_e.first || out_if.data[63:32] !== exp_e.second ||
            out_if.data[64] !== exp_e.ovf || out_if.data[65] !== exp_e.sing) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp x0=%h x1=%h ovf=%b sing=%b got x0=%h x1=%h ovf=%b sing=%b",
                     exp_e.first, exp_e.second, exp_e.ovf, exp_e.sing,
                     out_if.data[31:0], out_if.data[63:32], out_if.data[64], out_if.data[65]);
        end
      end
    end
    if (long_hold) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      hold_cycles <= $urandom_range(0, 4);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  localparam logic [63:0] ONE_LO = 64'h0000_0000_0001_0000;
  localparam logic [63:0] ONE_HI = 64'h0001_0000_0000_0000;

  task automatic test_directed();
    // reset defaults first, then rails of the inputs
    send_item(32'h0, 32'h0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000);
    send_item(32'hFFFF_FFFF, 32'h0001_0000);
    load_config(ONE_LO, ONE_HI, {32'h0000_0100, 32'h0001_0000}, ONE_LO,
                {32'h0, 32'h0000_0100}, {32'h0000_0100, 32'h0}, 32'h0001_0000);
    send_item(32'h7FFF_FFFF, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h0001_0000, 32'hFFFF_0000);
    // saturating coefficients everywhere
    load_config({2{32'h7FFF_FFFF}}, {2{32'h8000_0000}}, {2{32'h7FFF_FFFF}},
                {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h8000_0000}}, 32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h1234_5678, 32'hEDCB_A987);
    // zero innovation variance: no observation and no noise
    load_config(ONE_LO, ONE_HI, ONE_LO, 64'h0, ONE_LO, ONE_HI, 32'h0);
    send_item(32'h0002_0000, 32'h0);
    send_item(32'hFFFE_0000, 32'h0005_0000);
    // negative R cancelling a positive S keeps it singular
    load_config(ONE_LO, ONE_HI, 64'h0, ONE_LO, 64'h0, 64'h0, 32'h0);
    send_item(32'h0, 32'h0003_0000);
    load_config(ONE_LO, ONE_HI, 64'h0, ONE_LO, ONE_LO, 64'h0, 32'hFFFF_0000);
    send_item(32'h0, 32'h0003_0000);
    send_item(32'h0001_0000, 32'h0001_0000);
  endtask

  task automatic set_tracking_config();
    // constant-velocity model, dt about 1/256
    load_config({32'h0000_0100, 32'h0001_0000}, ONE_HI, {32'h0, 32'h0000_0100}, ONE_LO,
                {32'h0, 32'h0000_0040}, {32'h0000_0040, 32'h0}, 32'h0000_4000);
  endtask

  task automatic test_tracking(int n);
    set_tracking_config();
    repeat (n) send_item(rand_word(), rand_word());
  endtask

  task automatic test_random_config(int phases, int per_phase);
    repeat (phases) begin
      load_config({rand_word(), rand_word()}, {rand_word(), rand_word()},
                  {rand_word(), rand_word()}, {rand_word(), rand_word()},
                  {rand_word(), rand_word()}, {rand_word(), rand_word()}, rand_word());
      repeat (per_phase) send_item(rand_word(), rand_word());
    end
  endtask

  task automatic test_singular(int n);
    load_config({rand_word(), rand_word()}, {rand_word(), rand_word()},
                {rand_word(), rand_word()}, 64'h0, {rand_word(), rand_word()},
                {rand_word(), rand_word()}, 32'h0);
    repeat (n) send_item(rand_word(), rand_word());
  endtask

  task automatic test_backpressure(int n);
    set_tracking_config();
    // long hold on the result side while items keep coming
    fork
      begin
        @(posedge clk_i);
        long_hold <= 1'b1;
        repeat (2000) @(posedge clk_i);
        long_hold <= 1'b0;
      end
      repeat (n / 2) send_item(rand_word(), rand_word());
    join
    // sender waits for every result before continuing
    stop_sending();
    wait (estimate_q.size() == 0);
    repeat (n - n / 2) send_item(rand_word(), rand_word());
  endtask

  task automatic test_no_idle(int n);
    wait_idle();
    idle_en = 1'b0;
    set_tracking_config();
    repeat (n) send_item(rand_word(), rand_word());
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    m_a01 = ONE_LO; m_a23 = ONE_HI; m_b = 64'h0; m_c = ONE_LO;
    m_q01 = 64'h0; m_q23 = 64'h0; m_r = ONE_LO;
    est_x0 = 0; est_x1 = 0; cv11 = 0; cv12 = 0; cv21 = 0; cv22 = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_tracking(380);
    test_random_config(6, 50);
    test_singular(30);
    test_backpressure(150);
    test_no_idle(150);
    stop_sending();

    wait (estimate_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && estimate_q.size() == 0) begin
      $display("two_state_kalman_filter regression: pass");
    end else begin
      $display("two_state_kalman_filter regression: fail");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/tskf_pkg.sv
hdl/tskf_stream_if.sv
hdl/tskf_alu.sv
hdl/tskf_div.sv
hdl/two_state_kalman_filter.sv
verif/testbench.sv
